>>> design/cnlc_pkg.sv
// Package for the card number Luhn classifier.
// Holds widths, the controller state type and the Luhn digit term function.
// No dependencies; used by every module of the block.
package cnlc_pkg;

    // Field widths fixed by the interface.
    localparam int BIN_W      = 64;
    localparam int CLASS_W    = 2;
    localparam int COUNT_W    = 5;

    // Largest number of decimal digits that still gives a valid result.
    localparam int MAX_DIGITS = 19;

    // A 64-bit value has at most 20 decimal digits.
    localparam int DIGIT_SLOTS = 20;
    localparam int DIGIT_W     = 4;
    localparam int BCD_W       = DIGIT_SLOTS * DIGIT_W;
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);

    // The binary-to-BCD converter shifts this many bits in per cycle.
    localparam int STEP_BITS   = 4;
    localparam int CONV_CYCLES = BIN_W / STEP_BITS;
    localparam int CONV_CNT_W  = $clog2(CONV_CYCLES);

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CLASS_W-1:0] t_class;

    // Result classes.
    localparam t_class CLASS_INVALID = 2'd0;
    localparam t_class CLASS_15_3X   = 2'd1;
    localparam t_class CLASS_16_5X   = 2'd2;
    localparam t_class CLASS_1316_4  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Luhn contribution of one digit: doubled digits above 9 fold back by 9,
    // which equals the sum of the two decimal digits of the product.
    function automatic t_digit luhn_term(input t_digit d, input logic dbl);
        logic [DIGIT_W:0] v_two;
        begin
            v_two = {d, 1'b0};
            if (!dbl) begin
                luhn_term = d;
            end else if (v_two > 5'd9) begin
                luhn_term = DIGIT_W'(v_two - 5'd9);
            end else begin
                luhn_term = v_two[DIGIT_W-1:0];
            end
        end
    endfunction

endpackage

>>> design/cnlc_bcd_conv.sv
// Iterative binary-to-BCD converter (shift and add-3) for the classifier.
// Shifts STEP_BITS bits per cycle; depends on cnlc_pkg.
module cnlc_bcd_conv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cnlc_pkg::BIN_W-1:0] i_bin,
    output logic                      o_done,
    output logic [cnlc_pkg::BCD_W-1:0] o_bcd
);

    logic                              r_busy;
    logic                              r_done;
    logic [cnlc_pkg::CONV_CNT_W-1:0]   r_cnt;
    logic [cnlc_pkg::BIN_W-1:0]        r_bin;
    logic [cnlc_pkg::BCD_W-1:0]        r_bcd;
    logic [cnlc_pkg::BIN_W-1:0]        n_bin;
    logic [cnlc_pkg::BCD_W-1:0]        n_bcd;
    logic                              w_last;

    assign w_last = (r_cnt == cnlc_pkg::CONV_CNT_W'(cnlc_pkg::CONV_CYCLES - 1));

    // Several shift-and-adjust passes per cycle; each pass adjusts all
    // digits independently before the one-bit shift.
    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        for (int s = 0; s < cnlc_pkg::STEP_BITS; s++) begin
            for (int k = 0; k < cnlc_pkg::DIGIT_SLOTS; k++) begin
                if (n_bcd[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] >= 4'd5) begin
                    n_bcd[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
                        n_bcd[k*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] + 4'd3;
                end
            end
            n_bcd = {n_bcd[cnlc_pkg::BCD_W-2:0], n_bin[cnlc_pkg::BIN_W-1]};
            n_bin = {n_bin[cnlc_pkg::BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_done <= w_last;
            r_busy <= !w_last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> design/card_number_luhn_classifier.sv
// Top level of the card number Luhn classifier.
// Instantiates cnlc_bcd_conv and scans its decimal digits; depends on cnlc_pkg.
//
//  Channel | Direction | Handshake                 | Beat contents
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_card_number
//  out     | output    | o_out_valid / i_out_stall | o_card_class, o_check_ok, o_digit_count
//
// One beat is worked on at a time. The 64-bit number is converted to 20 BCD
// digits (four bits per cycle in the shift-and-add-3 converter), then one
// digit per cycle goes through the shared Luhn adder, and the final state forms
// the class and loads the result register. The next beat can be accepted once
// the controller has returned to idle after that load.
// The result sits in an output register, so a stalled output does not hold up
// the next input beat unless a second result is ready before the first leaves.
// Reset is synchronous and active low; it returns the controller to idle and
// empties the output register.
module card_number_luhn_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cnlc_pkg::BIN_W-1:0]    i_card_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cnlc_pkg::CLASS_W-1:0]  o_card_class,
    output logic                          o_check_ok,
    output logic [cnlc_pkg::COUNT_W-1:0]  o_digit_count
);

    cnlc_pkg::t_state r_state;
    cnlc_pkg::t_state n_state;

    logic                          w_in_acc;
    logic                          w_conv_done;
    logic [cnlc_pkg::BCD_W-1:0]    w_bcd;

    // Digit scan registers.
    logic [cnlc_pkg::BCD_W-1:0]    r_digits;
    cnlc_pkg::t_idx                r_idx;
    cnlc_pkg::t_digit              r_sum;
    cnlc_pkg::t_count              r_count;
    cnlc_pkg::t_digit              r_top;
    cnlc_pkg::t_digit              r_next;
    cnlc_pkg::t_digit              r_prev;

    // Output register.
    logic                          r_out_valid;
    cnlc_pkg::t_class              r_class;
    logic                          r_ok;
    cnlc_pkg::t_count              r_out_count;

    // Controller strobes.
    logic                          w_scan_load;
    logic                          w_scan_step;
    logic                          w_out_load;
    logic                          w_out_free;

    // Datapath values.
    cnlc_pkg::t_digit              w_digit;
    cnlc_pkg::t_digit              w_term;
    logic [cnlc_pkg::DIGIT_W:0]    w_sum_raw;
    cnlc_pkg::t_digit              n_sum;
    logic                          w_scan_last;
    logic                          w_overflow;
    logic                          w_pass;
    cnlc_pkg::t_class              n_class;

    assign o_in_stall = (r_state != cnlc_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    cnlc_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_bin   (i_card_number),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    assign w_scan_last = (r_idx == cnlc_pkg::IDX_W'(cnlc_pkg::DIGIT_SLOTS - 1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cnlc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = cnlc_pkg::ST_CONV;
                end
            end
            cnlc_pkg::ST_CONV: begin
                if (w_conv_done) begin
                    n_state = cnlc_pkg::ST_SCAN;
                end
            end
            cnlc_pkg::ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = cnlc_pkg::ST_FIN;
                end
            end
            cnlc_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = cnlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cnlc_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        w_scan_load = 1'b0;
        w_scan_step = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            cnlc_pkg::ST_CONV: begin
                w_scan_load = w_conv_done;
            end
            cnlc_pkg::ST_SCAN: begin
                w_scan_step = 1'b1;
            end
            cnlc_pkg::ST_FIN: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_scan_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cnlc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The shared Luhn unit: one digit per cycle from the least significant
    // end, with the running sum kept modulo ten by one compare and subtract.
    // Zeros above the leading digit add nothing, so the whole BCD word can be
    // scanned without knowing the length first.
    assign w_digit   = r_digits[cnlc_pkg::DIGIT_W-1:0];
    assign w_term    = cnlc_pkg::luhn_term(w_digit, r_idx[0]);
    assign w_sum_raw = {1'b0, r_sum} + {1'b0, w_term};
    assign n_sum     = (w_sum_raw >= 5'd10) ? cnlc_pkg::DIGIT_W'(w_sum_raw - 5'd10)
                                            : w_sum_raw[cnlc_pkg::DIGIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_scan_load) begin
            r_digits <= w_bcd;
            r_idx    <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_top    <= '0;
            r_next   <= '0;
            r_prev   <= '0;
        end else if (w_scan_step) begin
            r_digits <= {cnlc_pkg::DIGIT_W'(0), r_digits[cnlc_pkg::BCD_W-1:cnlc_pkg::DIGIT_W]};
            r_idx    <= r_idx + 1'b1;
            r_sum    <= n_sum;
            r_prev   <= w_digit;
            // The most recent nonzero digit is the leading one so far, and
            // the digit just below it is the second leading digit.
            if (w_digit != '0) begin
                r_count <= cnlc_pkg::t_count'(r_idx) + 1'b1;
                r_top   <= w_digit;
                r_next  <= r_prev;
            end
        end
    end

    // Classification from the length and the two leading digits. A number
    // longer than the supported length reports the overflow length and fails.
    assign w_overflow = (r_count > cnlc_pkg::t_count'(cnlc_pkg::MAX_DIGITS));
    assign w_pass     = (r_sum == '0) && !w_overflow;

    always_comb begin
        n_class = cnlc_pkg::CLASS_INVALID;
        if (w_pass) begin
            if ((r_count == 5'd15) && (r_top == 4'd3) && (r_next inside {4'd4, 4'd7})) begin
                n_class = cnlc_pkg::CLASS_15_3X;
            end else if ((r_count == 5'd16) && (r_top == 4'd5) &&
                         (r_next inside {[4'd1:4'd5]})) begin
                n_class = cnlc_pkg::CLASS_16_5X;
            end else if ((r_count inside {5'd13, 5'd16}) && (r_top == 4'd4)) begin
                n_class = cnlc_pkg::CLASS_1316_4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_class     <= n_class;
            r_ok        <= w_pass;
            r_out_count <= w_overflow ? cnlc_pkg::t_count'(cnlc_pkg::MAX_DIGITS + 1) : r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_card_class  = r_class;
    assign o_check_ok    = r_ok;
    assign o_digit_count = r_out_count;

    // The converter finishes only while the controller waits for it.
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |-> (r_state == cnlc_pkg::ST_CONV))
        else $error("converter finished outside the conversion state");

    // The running Luhn sum stays reduced modulo ten.
    a_sum_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cnlc_pkg::ST_SCAN) |-> (r_sum <= 4'd9))
        else $error("Luhn running sum left the range 0 to 9");

    // A classified card always passed the check.
    a_class_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_card_class != cnlc_pkg::CLASS_INVALID)) |-> o_check_ok)
        else $error("card class given without a passing check");

    // An accepted beat always starts a conversion.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == cnlc_pkg::ST_CONV))
        else $error("accepted beat did not start a conversion");

endmodule

>>> test/luhn_class_monitor.sv
// Monitor for the card number Luhn classifier: predicts each result from the
// accepted card number and compares it with the result beats. Uses cnlc_pkg.
module luhn_class_monitor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [cnlc_pkg::BIN_W-1:0] i_card_number,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  cnlc_pkg::t_class        i_card_class,
    input  logic                    i_check_ok,
    input  cnlc_pkg::t_count        i_digit_count,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cnlc_pkg::t_class card_class;
        logic             check_ok;
        cnlc_pkg::t_count digit_count;
    } t_card_verdict;

    t_card_verdict pending_verdicts[$];

    // Splits the number into decimal digits, runs the mod-10 sum and picks
    // the class from length and leading digits.
    function automatic t_card_verdict classify_card(input logic [cnlc_pkg::BIN_W-1:0] num);
        cnlc_pkg::t_digit              digs [cnlc_pkg::DIGIT_SLOTS];
        logic [cnlc_pkg::BIN_W-1:0]    rest;
        int unsigned   cnt;
        int unsigned   total;
        int unsigned   term;
        int unsigned   lead;
        int unsigned   second;
        t_card_verdict v;
        for (int j = 0; j < cnlc_pkg::DIGIT_SLOTS; j++) digs[j] = '0;
        rest  = num;
        cnt   = 0;
        total = 0;
        while (rest != '0 && cnt < cnlc_pkg::DIGIT_SLOTS) begin
            digs[cnt] = cnlc_pkg::t_digit'(rest % 64'd10);
            rest      = rest / 64'd10;
            cnt++;
        end
        v.card_class = cnlc_pkg::CLASS_INVALID;
        if (cnt > cnlc_pkg::MAX_DIGITS) begin
            v.check_ok    = 1'b0;
            v.digit_count = cnlc_pkg::t_count'(cnlc_pkg::MAX_DIGITS + 1);
            return v;
        end
        for (int unsigned j = 0; j < cnt; j++) begin
            term = digs[j];
            if (j % 2 == 1) begin
                term = term * 2;
                // Subtracting nine equals summing the two digits of the product.
                if (term > 9) term = term - 9;
            end
            total += term;
        end
        v.check_ok    = (total % 10 == 0);
        v.digit_count = cnlc_pkg::t_count'(cnt);
        if (v.check_ok && cnt >= 2) begin
            lead   = digs[cnt-1];
            second = digs[cnt-2];
            if (cnt == 15 && lead == 3 && (second == 4 || second == 7))
                v.card_class = cnlc_pkg::CLASS_15_3X;
            else if (cnt == 16 && lead == 5 && second >= 1 && second <= 5)
                v.card_class = cnlc_pkg::CLASS_16_5X;
            else if ((cnt == 13 || cnt == 16) && lead == 4)
                v.card_class = cnlc_pkg::CLASS_1316_4;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_card_verdict want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            pending_verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result beat with no card number pending: class %0d ok %0d count %0d",
                           i_card_class, i_check_ok, i_digit_count);
                    errs++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_card_class !== want.card_class) begin
                        $error("card_class: expected %0d, actual %0d",
                               want.card_class, i_card_class);
                        errs++;
                    end
                    if (i_check_ok !== want.check_ok) begin
                        $error("check_ok: expected %0d, actual %0d",
                               want.check_ok, i_check_ok);
                        errs++;
                    end
                    if (i_digit_count !== want.digit_count) begin
                        $error("digit_count: expected %0d, actual %0d",
                               want.digit_count, i_digit_count);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_verdicts.push_back(classify_card(i_card_number));
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= pending_verdicts.size();
    end

endmodule

>>> test/testbench.sv
// Top of the card number Luhn classifier testbench: clock, reset, card number
// stimulus and result stalls. Depends on cnlc_pkg, the block and luhn_class_monitor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of random card number beats after the directed ones.
    localparam int RANDOM_BEATS = 900;
    // Cycles waited at the end once no result is pending any more.
    localparam int DRAIN_CYCLES = 60;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic [cnlc_pkg::BIN_W-1:0]   i_card_number = '0;
    logic                         i_out_stall   = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    cnlc_pkg::t_class             o_card_class;
    logic                         o_check_ok;
    cnlc_pkg::t_count             o_digit_count;

    int fail_count;
    int pending_count;

    // While this is set neither side inserts gaps, so each beat is offered as soon as the one before is taken.
    bit quiet_phase = 1'b0;

    always #5ns i_clk = ~i_clk;

    card_number_luhn_classifier u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_card_number (i_card_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_card_class  (o_card_class),
        .o_check_ok    (o_check_ok),
        .o_digit_count (o_digit_count)
    );

    luhn_class_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_card_number (i_card_number),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_card_class  (o_card_class),
        .i_check_ok    (o_check_ok),
        .i_digit_count (o_digit_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Both sides draw a fresh random wait for every beat, except in quiet phases
    // where the channels run without waits.
    function automatic int unsigned draw_wait();
        return quiet_phase ? 0 : $urandom_range(0, 7);
    endfunction

    // Builds an n-digit card number (n from 2 to 19) with the given leading
    // digits and random middle digits. The last digit is chosen so that the
    // mod-10 check passes, or deliberately made wrong when good_check is 0.
    function automatic logic [cnlc_pkg::BIN_W-1:0] make_card(input int unsigned n,
                                                             input int unsigned lead,
                                                             input int unsigned second,
                                                             input bit good_check);
        int unsigned                digs [cnlc_pkg::MAX_DIGITS];
        int unsigned                total;
        int unsigned                term;
        int unsigned                chk;
        logic [cnlc_pkg::BIN_W-1:0] num;
        for (int unsigned j = 0; j < n; j++) digs[j] = $urandom_range(0, 9);
        digs[n-1] = lead;
        digs[n-2] = second;
        total = 0;
        for (int unsigned j = 1; j < n; j++) begin
            term = digs[j];
            if (j % 2 == 1) begin
                term = term * 2;
                if (term > 9) term = term - 9;
            end
            total += term;
        end
        chk = (10 - total % 10) % 10;
        if (!good_check) chk = (chk + $urandom_range(1, 9)) % 10;
        // For two-digit numbers the check digit replaces the second digit.
        digs[0] = chk;
        num = '0;
        for (int j = int'(n) - 1; j >= 0; j--) num = num * 64'd10 + 64'(digs[j]);
        return num;
    endfunction

    // Offers one card number beat after a random gap and returns at the
    // falling edge after it has been taken. The valid is only dropped when a
    // gap follows, so back-to-back beats keep it high without a glitch.
    task automatic send_card(input logic [cnlc_pkg::BIN_W-1:0] card);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_card_number <= card;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Main stimulus: reset, a directed set of card numbers, then random ones,
    // then the drain and the verdict.
    initial begin : card_source
        int unsigned                pick;
        int unsigned                n;
        int unsigned                lead;
        int unsigned                second;
        bit                         good_check;
        logic [cnlc_pkg::BIN_W-1:0] card;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero has no digits, a single digit, and the edges of the 64-bit range.
        send_card(64'd0);
        send_card(64'd1);
        send_card(64'd18);
        send_card(64'hFFFF_FFFF_FFFF_FFFF);
        send_card(64'h8000_0000_0000_0000);
        send_card(64'h5555_5555_5555_5555);
        send_card(64'hAAAA_AAAA_AAAA_AAAA);
        // The largest 19-digit number and the smallest one with too many digits.
        send_card(64'd9999999999999999999);
        send_card(64'd10000000000000000000);
        // Each class, twice with a good check digit and once with a bad one.
        send_card(make_card(15, 3, 4, 1'b1));
        send_card(make_card(15, 3, 7, 1'b1));
        send_card(make_card(15, 3, 4, 1'b0));
        send_card(make_card(16, 5, 1, 1'b1));
        send_card(make_card(16, 5, 5, 1'b1));
        send_card(make_card(16, 5, 3, 1'b0));
        send_card(make_card(13, 4, 0, 1'b1));
        send_card(make_card(16, 4, 9, 1'b1));
        send_card(make_card(13, 4, 2, 1'b0));
        // Near misses: right prefix with the wrong length, or the other way round.
        send_card(make_card(15, 3, 5, 1'b1));
        send_card(make_card(16, 5, 0, 1'b1));
        send_card(make_card(16, 5, 6, 1'b1));
        send_card(make_card(14, 4, 1, 1'b1));
        send_card(make_card(15, 4, 1, 1'b1));
        send_card(make_card(19, 9, 9, 1'b1));

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            // Every third block of a hundred beats runs without gaps.
            quiet_phase = ((i / 100) % 3 == 2);
            pick       = $urandom_range(0, 99);
            good_check = ($urandom_range(0, 99) < 80);
            if (pick < 75) begin
                // Well-formed card numbers around the class boundaries.
                lead   = $urandom_range(1, 9);
                second = $urandom_range(0, 9);
                case ($urandom_range(0, 7))
                    0: begin n = 15; lead = 3; second = $urandom_range(0, 1) ? 4 : 7; end
                    1: begin n = 16; lead = 5; second = $urandom_range(1, 5); end
                    2: begin n = 13; lead = 4; end
                    3: begin n = 16; lead = 4; end
                    4: begin
                        lead = 4;
                        case ($urandom_range(0, 3))
                            0: n = 12;
                            1: n = 14;
                            2: n = 15;
                            default: n = 17;
                        endcase
                    end
                    5: begin
                        if ($urandom_range(0, 1)) begin n = 15; lead = 3; end
                        else begin n = 16; lead = 5; end
                    end
                    6: n = $urandom_range(2, 19);
                    default: n = 16;
                endcase
                card = make_card(n, lead, second, good_check);
            end else if (pick < 88) begin
                // Raw 64-bit noise, often with too many digits.
                card = {$urandom, $urandom};
            end else if (pick < 95) begin
                // Exactly twenty digits, just past the supported length.
                card = {$urandom, $urandom};
                card[63:62] = 2'b00;
                card = card + 64'd10000000000000000000;
            end else begin
                // Short numbers, zero included.
                card = 64'($urandom_range(0, 999));
            end
            send_card(card);
        end

        i_in_valid <= 1'b0;
        quiet_phase = 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: for each result beat a stall length is drawn, counted from
    // the first cycle the beat is offered, so stalls hit results as they appear.
    initial begin : result_sink
        int unsigned hold;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = draw_wait();
            i_out_stall <= (hold != 0);
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (hold != 0) begin
                repeat (hold - 1) @(posedge i_clk);
                @(negedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
            @(negedge i_clk);
        end
    end

    // Hard stop: the slowest correct run needs well under half a millisecond.
    initial begin : run_limit
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
